// ===== src/ut2cal_pkg.sv =====
// shared types, constants and helper functions for the unix time to calendar converter
`timescale 1ns / 1ps

package ut2cal_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEC,
        ST_MIN,
        ST_HOUR,
        ST_WDAY,
        ST_YEAR,
        ST_MONTH,
        ST_DONE
    } state_t;

    // width of the shared subtract and compare unit
    localparam int UNIT_W = 16;

    // reciprocals for exact division by constants, quotient = (x * recip) >> shift
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;  // shift 37, exact for any 32-bit x
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;  // shift 36, exact for any 32-bit x
    localparam logic [31:0] RECIP_7  = 32'h9249_2493;  // shift 34, exact for any x below 2^31

    // divisors, only the low remainder bits are formed
    localparam logic [5:0] DIV_SEC  = 6'd60;
    localparam logic [5:0] DIV_MIN  = 6'd60;
    localparam logic [5:0] DIV_HOUR = 6'd24;
    localparam logic [5:0] DIV_WDAY = 6'd7;

    // epoch start and the matching position inside the 100 and 400 year cycles
    localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
    localparam logic [6:0]  EPOCH_Y100  = 7'd70;
    localparam logic [8:0]  EPOCH_Y400  = 9'd370;
    localparam logic [6:0]  LAST_Y100   = 7'd99;
    localparam logic [8:0]  LAST_Y400   = 9'd399;

    localparam logic [UNIT_W-1:0] LEAP_YEAR_LEN   = 16'd366;
    localparam logic [UNIT_W-1:0] COMMON_YEAR_LEN = 16'd365;

    localparam logic [3:0] MONTH_FEB = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd11;

    // month length by zero-based month index, february lengthened in leap years
    function automatic logic [UNIT_W-1:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        begin
            case (idx)
                4'd0:      len = 5'd31;
                MONTH_FEB: len = leap ? 5'd29 : 5'd28;
                4'd2:      len = 5'd31;
                4'd3:      len = 5'd30;
                4'd4:      len = 5'd31;
                4'd5:      len = 5'd30;
                4'd6:      len = 5'd31;
                4'd7:      len = 5'd31;
                4'd8:      len = 5'd30;
                4'd9:      len = 5'd31;
                4'd10:     len = 5'd30;
                default:   len = 5'd31;
            endcase
            return {11'd0, len};
        end
    endfunction

    // day count mod 7 to weekday, day zero was a thursday, monday is 1
    function automatic logic [2:0] weekday_of(input logic [2:0] r);
        logic [2:0] wd;
        begin
            case (r)
                3'd0:    wd = 3'd4;
                3'd1:    wd = 3'd5;
                3'd2:    wd = 3'd6;
                3'd3:    wd = 3'd7;
                3'd4:    wd = 3'd1;
                3'd5:    wd = 3'd2;
                default: wd = 3'd3;
            endcase
            return wd;
        end
    endfunction

endpackage

// ===== src/unix_time_to_calendar.sv =====
// top level: sequential unix seconds to gregorian calendar converter
//
// usage: an input transfer on in_valid/in_ready carries epoch_seconds, an unsigned
// count of seconds since 1970-01-01 00:00:00. One result transfer on
// out_valid/out_ready follows, carrying year, month, day, hour, minute, second
// and weekday (1 monday .. 7 sunday).
// A shared 32x32 multiplier splits off seconds, minutes, hours and the weekday
// by reciprocal multiplication, each division in two steps (quotient, then
// remainder). A shared 16-bit subtract and compare unit then strips whole
// years until a borrow, and whole months until a borrow or december,
// december absorbing the rest.
// The year search dominates the conversion time.
// in_ready is high only while idle, so one item is in flight at a time.
// If the receiver stalls, the result stays registered and stable on the
// outputs until taken; the next item can be accepted in the cycle after that.
// rst_n (asynchronous, active low) aborts any conversion and returns to idle.
`timescale 1ns / 1ps

module unix_time_to_calendar
    import ut2cal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year_out,
    output logic [3:0]  month_out,
    output logic [4:0]  day_out,
    output logic [4:0]  hour_out,
    output logic [5:0]  minute_out,
    output logic [5:0]  second_out,
    output logic [2:0]  weekday_out
);

    state_t state_reg, state_next;

    logic [31:0] num_reg, num_next;
    logic [31:0] quo_reg, quo_next;
    logic        phase_reg, phase_next;
    logic [15:0] days_reg, days_next;
    logic [11:0] year_reg, year_next;
    logic [6:0]  y100_reg, y100_next;
    logic [8:0]  y400_reg, y400_next;
    logic [3:0]  mon_reg, mon_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [2:0]  wday_reg, wday_next;

    // shared subtract and compare unit
    logic [UNIT_W-1:0] unit_a, unit_b;
    logic [UNIT_W:0]   unit_diff;
    logic              unit_borrow;

    // shared reciprocal multiplier
    logic [31:0] mul_b;
    logic [63:0] mul_prod;
    logic [31:0] quo_calc;

    // remainder from dividend and registered quotient, low bits only
    logic [5:0] div_lo;
    logic [5:0] rem_prod;
    logic [5:0] rem_calc;

    logic       leap;

    assign unit_diff   = {1'b0, unit_a} - {1'b0, unit_b};
    assign unit_borrow = unit_diff[UNIT_W];

    assign mul_prod = 64'(num_reg) * 64'(mul_b);
    assign rem_prod = quo_reg[5:0] * div_lo;
    assign rem_calc = num_reg[5:0] - rem_prod;

    // full gregorian leap rule from the running year position counters
    assign leap = ((year_reg[1:0] == 2'd0) && (y100_reg != 7'd0)) || (y400_reg == 9'd0);

    // unit operand selection
    always_comb
    begin
        unit_a = '0;
        unit_b = '0;
        mul_b  = '0;
        div_lo = '0;
        unique case (state_reg)
            ST_SEC:
            begin
                mul_b  = RECIP_60;
                div_lo = DIV_SEC;
            end
            ST_MIN:
            begin
                mul_b  = RECIP_60;
                div_lo = DIV_MIN;
            end
            ST_HOUR:
            begin
                mul_b  = RECIP_24;
                div_lo = DIV_HOUR;
            end
            ST_WDAY:
            begin
                mul_b  = RECIP_7;
                div_lo = DIV_WDAY;
            end
            ST_YEAR:
            begin
                unit_a = days_reg;
                unit_b = leap ? LEAP_YEAR_LEN : COMMON_YEAR_LEN;
            end
            ST_MONTH:
            begin
                unit_a = days_reg;
                unit_b = month_len(mon_reg, leap);
            end
            default:
            begin
                unit_a = '0;
                unit_b = '0;
            end
        endcase
    end

    // quotient from the high product bits
    always_comb
    begin
        quo_calc = '0;
        unique case (state_reg)
            ST_SEC:  quo_calc = {5'd0, mul_prod[63:37]};
            ST_MIN:  quo_calc = {5'd0, mul_prod[63:37]};
            ST_HOUR: quo_calc = {4'd0, mul_prod[63:36]};
            ST_WDAY: quo_calc = {2'd0, mul_prod[63:34]};
            default: quo_calc = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SEC;
            ST_SEC:   if (phase_reg) state_next = ST_MIN;
            ST_MIN:   if (phase_reg) state_next = ST_HOUR;
            ST_HOUR:  if (phase_reg) state_next = ST_WDAY;
            ST_WDAY:  if (phase_reg) state_next = ST_YEAR;
            ST_YEAR:  if (unit_borrow) state_next = ST_MONTH;
            ST_MONTH: if (unit_borrow || (mon_reg == MONTH_DEC)) state_next = ST_DONE;
            ST_DONE:  if (out_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb
    begin
        num_next   = num_reg;
        quo_next   = quo_reg;
        phase_next = phase_reg;
        days_next  = days_reg;
        year_next  = year_reg;
        y100_next  = y100_reg;
        y400_next  = y400_reg;
        mon_next   = mon_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        wday_next  = wday_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                num_next   = epoch_seconds;
                phase_next = 1'b0;
            end
            ST_SEC:
            begin
                // quotient first, then remainder and the quotient becomes the dividend
                phase_next = ~phase_reg;
                if (!phase_reg)
                begin
                    quo_next = quo_calc;
                end
                else
                begin
                    sec_next = rem_calc;
                    num_next = quo_reg;
                end
            end
            ST_MIN:
            begin
                phase_next = ~phase_reg;
                if (!phase_reg)
                begin
                    quo_next = quo_calc;
                end
                else
                begin
                    min_next = rem_calc;
                    num_next = quo_reg;
                end
            end
            ST_HOUR:
            begin
                phase_next = ~phase_reg;
                if (!phase_reg)
                begin
                    quo_next = quo_calc;
                end
                else
                begin
                    hour_next = rem_calc[4:0];
                    days_next = quo_reg[15:0];
                    num_next  = quo_reg;
                end
            end
            ST_WDAY:
            begin
                phase_next = ~phase_reg;
                if (!phase_reg)
                begin
                    quo_next = quo_calc;
                end
                else
                begin
                    wday_next = weekday_of(rem_calc[2:0]);
                    year_next = EPOCH_YEAR;
                    y100_next = EPOCH_Y100;
                    y400_next = EPOCH_Y400;
                end
            end
            ST_YEAR:
            begin
                // strip whole years
                if (unit_borrow)
                begin
                    mon_next = '0;
                end
                else
                begin
                    days_next = unit_diff[15:0];
                    year_next = year_reg + 12'd1;
                    y100_next = (y100_reg == LAST_Y100) ? 7'd0 : y100_reg + 7'd1;
                    y400_next = (y400_reg == LAST_Y400) ? 9'd0 : y400_reg + 9'd1;
                end
            end
            ST_MONTH:
            begin
                // strip whole months, december absorbs the rest
                if (!unit_borrow && (mon_reg != MONTH_DEC))
                begin
                    days_next = unit_diff[15:0];
                    mon_next  = mon_reg + 4'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        quo_reg   <= quo_next;
        phase_reg <= phase_next;
        days_reg  <= days_next;
        year_reg  <= year_next;
        y100_reg  <= y100_next;
        y400_reg  <= y400_next;
        mon_reg   <= mon_next;
        sec_reg   <= sec_next;
        min_reg   <= min_next;
        hour_reg  <= hour_next;
        wday_reg  <= wday_next;
    end

    // handshake and result outputs
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_DONE);
    assign year_out    = year_reg;
    assign month_out   = mon_reg + 4'd1;
    assign day_out     = days_reg[4:0] + 5'd1;
    assign hour_out    = hour_reg;
    assign minute_out  = min_reg;
    assign second_out  = sec_reg;
    assign weekday_out = wday_reg;

endmodule
